[hdl/ws_pkg.sv]
// Shared types, constants and the bit-expansion function for the WS2812 SPI frame encoder.
// Depends on nothing; every other file of the block imports it.
package ws_pkg;

   localparam int LED_COUNT_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic       CMD_SET   = 1'b0;
   localparam logic       CMD_SEND  = 1'b1;
   localparam logic [7:0] ALL_LEDS  = 8'd255;
   localparam logic [2:0] CODE_ONE  = 3'b110;
   localparam logic [2:0] CODE_ZERO = 3'b100;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      OP_SET_ONE,
      OP_SET_ALL,
      OP_SEND
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  index;
      logic [23:0] color;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic [23:0] spi_word;
      logic [3:0]  led_number;
      logic [1:0]  channel;
      logic        last;
   } rsp_type;

   // Each colour bit becomes three line bits, MSB first.
   function automatic logic [23:0] expand_byte(input logic [7:0] value);
      logic [23:0] word;
      word = '0;
      for (int b = 0; b < 8; b++) begin
         word[3*b +: 3] = value[b] ? CODE_ONE : CODE_ZERO;
      end
      return word;
   endfunction

endpackage

[hdl/ws_front.sv]
// Command front end: classifies each accepted beat and queues every send or valid set.
// Depends on ws_pkg.
module ws_front #(
   parameter int LED_COUNT = ws_pkg::LED_COUNT_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           queue_full,
   input  logic           cmd,
   input  logic [7:0]     index,
   input  logic [23:0]    color,
   output logic           busy,
   output logic           push,
   output ws_pkg::cmd_type push_cmd
);
   import ws_pkg::*;

   logic accepted;
   logic busy_ff;
   logic busy_in;

   // Busy follows the queue's full flag, and a registered copy of that flag holds it up
   // through the first cycle in which the queue has room again.
   assign busy_in  = queue_full;
   assign busy     = busy_ff | queue_full;
   assign accepted = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      push           = 1'b0;
      push_cmd.op    = OP_SEND;
      push_cmd.index = index;
      push_cmd.color = color;
      if (accepted) begin
         if (cmd == CMD_SEND) begin
            push        = 1'b1;
            push_cmd.op = OP_SEND;
         end else if (index < 8'(LED_COUNT)) begin
            push        = 1'b1;
            push_cmd.op = OP_SET_ONE;
         end else if (index == ALL_LEDS) begin
            push        = 1'b1;
            push_cmd.op = OP_SET_ALL;
         end
         // Any other set index is dropped here: it changes nothing and returns nothing.
      end
   end

endmodule

[hdl/ws_queue.sv]
// Short command queue between the front end and the frame engine.
// Depends on ws_pkg.
module ws_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ws_pkg::cmd_type push_cmd,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output ws_pkg::cmd_type head
);
   import ws_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         buffer_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = buffer_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buffer_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/ws_back.sv]
// Frame engine: owns the colour store, carries out set, set-all and send commands.
// Depends on ws_pkg; takes commands from ws_queue.
module ws_back #(
   parameter int LED_COUNT = ws_pkg::LED_COUNT_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  ws_pkg::cmd_type cmd,
   output logic            pop,
   output ws_pkg::rsp_type rsp
);
   import ws_pkg::*;

   localparam int IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam logic [IdxW-1:0] LastLed = IdxW'(LED_COUNT - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_SWEEP,
      S_READ,
      S_EMIT
   } state_type;

   state_type       state_ff, state_in;
   logic [IdxW-1:0] addr_ff, addr_in;
   logic [23:0]     color_ff, color_in;
   logic [1:0]      chan_ff, chan_in;
   logic [LED_COUNT-1:0] valid_ff, valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [23:0]     mem [LED_COUNT];
   logic [23:0]     rd_data_ff;
   logic            rd_valid_ff;
   logic            mem_we;
   logic [23:0]     entry;
   logic [7:0]      chan_byte;
   logic [7:0]      led_ext;

   assign mem_we  = (state_ff == S_WRITE) || (state_ff == S_SWEEP);
   assign pop     = (state_ff == S_IDLE) && cmd_valid;
   assign rsp     = rsp_ff;
   // Entries never written since reset read as off.
   assign entry   = rd_valid_ff ? rd_data_ff : 24'h000000;
   assign led_ext = 8'(addr_ff);

   always_comb begin
      case (chan_ff)
         CH_RED:   chan_byte = entry[23:16];
         CH_GREEN: chan_byte = entry[15:8];
         default:  chan_byte = entry[7:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      color_in = color_ff;
      chan_in  = chan_ff;
      valid_in = valid_ff;
      rsp_in   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               color_in = cmd.color;
               chan_in  = CH_RED;
               unique case (cmd.op)
                  OP_SET_ONE: begin
                     state_in = S_WRITE;
                     addr_in  = cmd.index[IdxW-1:0];
                  end
                  OP_SET_ALL: begin
                     state_in = S_SWEEP;
                     addr_in  = '0;
                  end
                  OP_SEND: begin
                     state_in = S_READ;
                     addr_in  = '0;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WRITE: begin
            valid_in[addr_ff] = 1'b1;
            state_in          = S_IDLE;
         end
         S_SWEEP: begin
            valid_in[addr_ff] = 1'b1;
            if (addr_ff == LastLed) begin
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_READ: begin
            state_in = S_EMIT;
            chan_in  = CH_RED;
         end
         S_EMIT: begin
            rsp_in.valid      = 1'b1;
            rsp_in.spi_word   = expand_byte(chan_byte);
            rsp_in.led_number = led_ext[3:0];
            rsp_in.channel    = chan_ff;
            rsp_in.last       = (chan_ff == CH_BLUE) && (addr_ff == LastLed);
            if (chan_ff == CH_BLUE) begin
               if (addr_ff == LastLed) begin
                  state_in = S_IDLE;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  state_in = S_READ;
               end
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         addr_ff  <= '0;
         chan_ff  <= CH_RED;
         valid_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
         rsp_ff   <= rsp_in;
      end
      color_ff <= color_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= color_ff;
      end
      rd_data_ff  <= mem[addr_ff];
      rd_valid_ff <= valid_ff[addr_ff];
   end

endmodule

[hdl/ws2812_spi_frame_encoder.sv]
// Top level of the WS2812 SPI frame encoder: front end, command queue and frame engine.
// Depends on ws_pkg, ws_front, ws_queue and ws_back.

// A command beat is taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full and falls in the cycle after the queue has room again.
// A set writes one colour in the S_WRITE state, set-all sweeps the colour store at one
// entry per cycle, and a set with any other index is dropped at once. A send emits
// 3 * LED_COUNT words, one per strobe cycle, in bursts of three consecutive words per
// LED; each LED takes one store read, then its red, green and blue words. The result
// ports carry each word for exactly one cycle and the receiver cannot stall them. The
// colour store resets to all off through per-entry valid bits, so no clearing pass is
// needed.
module ws2812_spi_frame_encoder #(
   parameter int LED_COUNT = ws_pkg::LED_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [7:0]  req_index,
   input  logic [23:0] req_color,
   output logic        rsp_strobe,
   output logic [23:0] rsp_spi_word,
   output logic [3:0]  rsp_led_number,
   output logic [1:0]  rsp_channel,
   output logic        rsp_last
);
   import ws_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_not_empty;
   cmd_type queue_head;
   logic    pop;
   rsp_type rsp;

   ws_front #(.LED_COUNT(LED_COUNT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .queue_full (queue_full),
      .cmd        (req_cmd),
      .index      (req_index),
      .color      (req_color),
      .busy       (busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ws_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   ws_back #(.LED_COUNT(LED_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_head),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_strobe     = rsp.valid;
   assign rsp_spi_word   = rsp.spi_word;
   assign rsp_led_number = rsp.led_number;
   assign rsp_channel    = rsp.channel;
   assign rsp_last       = rsp.last;

`ifndef SYNTH
   // The final word of a frame is always the blue word of the highest LED.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_channel == CH_BLUE &&
         rsp_led_number == 4'((LED_COUNT - 1) % 16))
      else $error("last flag on a word that does not end the frame");

   // The three words of one LED come out on consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_channel == CH_RED |=>
         rsp_strobe && rsp_channel == CH_GREEN && $stable(rsp_led_number))
      else $error("green word did not follow red word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_channel == CH_GREEN |=>
         rsp_strobe && rsp_channel == CH_BLUE && $stable(rsp_led_number))
      else $error("blue word did not follow green word");
`endif

endmodule
